// ----- rtl/core/esrf_pkg.sv -----
package esrf_pkg;

  // Fixed field widths
  localparam int unsigned PROB_W   = 16;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned ELEM_W   = 6;
  localparam int unsigned KEPT_W   = 16;
  localparam int unsigned RL_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Parameter defaults
  localparam int unsigned MAX_ROW_LEN_DEFAULT     = 64;
  localparam int unsigned TERM_TABLE_BITS_DEFAULT = 10;

  // ln 2 in Q0.16
  localparam longint unsigned LN2_Q16 = 45426;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTROPY_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH        = 2'd2;

  // Reset values of the registers
  localparam logic [SUM_W-1:0]  ENTROPY_THRESHOLD_RESET = 24'hFFFFFF;
  localparam logic [PROB_W-1:0] SCORE_THRESHOLD_RESET   = 16'h0000;
  localparam logic [RL_W-1:0]   ROW_LENGTH_RESET        = 7'd64;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;       // input word taken this cycle
    logic judge;        // last term of a finished row is in the term register
    logic load_req;     // finished row is kept: queue it for draining
    logic start_drain;  // queued row becomes the draining row
    logic issue;        // read one stored word into the output register
  } esrf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic row_done;     // a word taken now closes the row
    logic keep;         // row under judgement passes both thresholds
    logic issue_last;   // drain pointer sits on the final element
    logic fill_bank;
    logic drain_bank;
    logic req_bank;
  } esrf_status_t;

  // One entry of the -p ln p table, Q0.16, for bin k of a table on the top
  // 'bits' probability bits. Bin midpoint m / 2^(bits+1), m = 2k+1.
  function automatic logic [15:0] term_entry(input int unsigned k, input int unsigned bits);
    longint unsigned m;
    longint unsigned x;
    longint unsigned g;
    longint unsigned prod;
    longint unsigned t;
    int unsigned     n;
    int unsigned     frac;
    int              i;
    m    = 64'(2 * k + 1);
    n    = 0;
    frac = 0;
    while (n < 31 && (m >> (n + 1)) != 0) n++;
    // mantissa in Q2.30, fraction bits of log2 by repeated squaring
    x = m << (30 - n);
    for (i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | (32'd1 << i);
      end
    end
    g    = (64'(bits + 1) << 16) - ((64'(n) << 16) | 64'(frac));
    prod = m * g * LN2_Q16;
    t    = (prod + (64'd1 << (bits + 16))) >> (bits + 17);
    if (t > 64'd65535) t = 64'd65535;
    return t[15:0];
  endfunction

endpackage

// ----- rtl/core/esrf_ctrl.sv -----
module esrf_ctrl
  import esrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         out_stall,
  output logic         out_valid,
  input  esrf_status_t status,
  output esrf_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   judge;
  logic   req_pending;
  logic   req_pending_next;
  logic   out_valid_next;
  logic   draining;
  logic   advance;

  // Hold input off a bank that is still draining or queued to drain
  always_comb begin
    draining = (state == ST_DRAIN);
    in_stall = (draining && (status.fill_bank == status.drain_bank)) ||
               (req_pending && (status.fill_bank == status.req_bank));
    advance  = !out_valid || !out_stall;

    cmd.accept      = in_valid && !in_stall;
    cmd.judge       = judge;
    cmd.load_req    = judge && status.keep;
    cmd.start_drain = req_pending && !draining;
    cmd.issue       = draining && advance;
  end

  // Drain sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd.start_drain) state_next = ST_DRAIN;
      ST_DRAIN: if (cmd.issue && status.issue_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_pending_next = cmd.load_req || (req_pending && !cmd.start_drain);
    if (cmd.issue) begin
      out_valid_next = 1'b1;
    end else if (advance) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      judge       <= 1'b0;
      req_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      judge       <= cmd.accept && status.row_done;
      req_pending <= req_pending_next;
      out_valid   <= out_valid_next;
    end
  end

endmodule

// ----- rtl/core/esrf_datapath.sv -----
module esrf_datapath
  import esrf_pkg::*;
#(
  parameter int unsigned MAX_ROW_LEN     = MAX_ROW_LEN_DEFAULT,
  parameter int unsigned TERM_TABLE_BITS = TERM_TABLE_BITS_DEFAULT
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  esrf_cmd_t             cmd,
  output esrf_status_t          status,
  input  logic [PROB_W-1:0]     probability,
  input  logic                  config_write,
  input  logic [CFG_IDX_W-1:0]  config_index,
  input  logic [CFG_DATA_W-1:0] config_data,
  output logic [PROB_W-1:0]     value,
  output logic [ELEM_W-1:0]     element_index,
  output logic [KEPT_W-1:0]     kept_row,
  output logic                  last
);

  localparam int unsigned IDX_W      = $clog2(MAX_ROW_LEN);
  localparam int unsigned CNT_W      = $clog2(MAX_ROW_LEN + 1);
  localparam int unsigned TABLE_SIZE = 1 << TERM_TABLE_BITS;
  localparam int unsigned MEM_DEPTH  = 1 << (IDX_W + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROW_LEN - 1);
  localparam logic [RL_W-1:0]  MAX_LEN  = RL_W'(MAX_ROW_LEN);

  // Configuration registers
  logic [SUM_W-1:0]  entropy_threshold;
  logic [PROB_W-1:0] score_threshold;
  logic [RL_W-1:0]   row_length;

  // Row accumulation
  logic [PROB_W-1:0] term;
  logic [SUM_W-1:0]  entropy_sum;
  logic [PROB_W-1:0] row_maximum;
  logic [CNT_W-1:0]  element_count;
  logic              fill_bank;

  // Row under judgement
  logic [PROB_W-1:0] judge_max;
  logic [CNT_W-1:0]  judge_len;
  logic              judge_bank;

  // Queued and draining rows
  logic              req_bank;
  logic [CNT_W-1:0]  req_len;
  logic [KEPT_W-1:0] req_tag;
  logic              drain_bank;
  logic [CNT_W-1:0]  drain_len;
  logic [KEPT_W-1:0] drain_tag;
  logic [IDX_W-1:0]  drain_ptr;
  logic [KEPT_W-1:0] kept_row_count;

  logic [PROB_W-1:0] row_store [MEM_DEPTH];
  logic [15:0]       term_rom [TABLE_SIZE];

  logic [CNT_W-1:0]  eff_len;
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  count;
  logic [PROB_W-1:0] max_upd;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic [TERM_TABLE_BITS-1:0] term_idx;

  // -p ln p table, constant per bin
  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
    assign term_rom[k] = term_entry(k, TERM_TABLE_BITS);
  end

  always_comb begin
    // out-of-range lengths: zero acts as one, long ones clip to the store
    if (row_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (row_length > MAX_LEN) begin
      eff_len = CNT_W'(MAX_ROW_LEN);
    end else begin
      eff_len = row_length[CNT_W-1:0];
    end
    if (element_count > CNT_W'(MAX_ROW_LEN - 1)) begin
      wr_idx = LAST_IDX;
    end else begin
      wr_idx = element_count[IDX_W-1:0];
    end
    count    = CNT_W'(wr_idx) + CNT_W'(1);
    max_upd  = (probability > row_maximum) ? probability : row_maximum;
    term_idx = probability[PROB_W-1 -: TERM_TABLE_BITS];

    // saturating accumulate of the registered term
    sum_wide = {1'b0, entropy_sum} + (SUM_W + 1)'(term);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    status.row_done   = (count >= eff_len);
    status.keep       = (sum_sat < entropy_threshold) && (judge_max > score_threshold);
    status.issue_last = ((CNT_W'(drain_ptr) + CNT_W'(1)) == drain_len);
    status.fill_bank  = fill_bank;
    status.drain_bank = drain_bank;
    status.req_bank   = req_bank;
  end

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      entropy_threshold <= ENTROPY_THRESHOLD_RESET;
      score_threshold   <= SCORE_THRESHOLD_RESET;
      row_length        <= ROW_LENGTH_RESET;
    end else if (config_write) begin
      case (config_index)
        REG_ENTROPY_THRESHOLD: entropy_threshold <= config_data[SUM_W-1:0];
        REG_SCORE_THRESHOLD:   score_threshold   <= config_data[PROB_W-1:0];
        REG_ROW_LENGTH:        row_length        <= config_data[RL_W-1:0];
        default: ;
      endcase
    end
  end

  // Term lookup (zero when idle or for a zero probability) and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      term           <= '0;
      entropy_sum    <= '0;
      row_maximum    <= '0;
      element_count  <= '0;
      fill_bank      <= 1'b0;
      kept_row_count <= '0;
    end else begin
      if (cmd.accept && (probability != '0)) begin
        term <= term_rom[term_idx];
      end else begin
        term <= '0;
      end
      entropy_sum <= cmd.judge ? '0 : sum_sat;
      if (cmd.accept) begin
        if (status.row_done) begin
          row_maximum   <= '0;
          element_count <= '0;
          fill_bank     <= !fill_bank;
        end else begin
          row_maximum   <= max_upd;
          element_count <= count;
        end
      end
      if (cmd.load_req && (kept_row_count != KEPT_MAX)) begin
        kept_row_count <= kept_row_count + KEPT_W'(1);
      end
    end
  end

  // Snapshot of a closed row, queue and drain bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept && status.row_done) begin
      judge_max  <= max_upd;
      judge_len  <= count;
      judge_bank <= fill_bank;
    end
    if (cmd.load_req) begin
      req_bank <= judge_bank;
      req_len  <= judge_len;
      req_tag  <= kept_row_count;
    end
    if (cmd.start_drain) begin
      drain_bank <= req_bank;
      drain_len  <= req_len;
      drain_tag  <= req_tag;
      drain_ptr  <= '0;
    end else if (cmd.issue) begin
      drain_ptr  <= drain_ptr + IDX_W'(1);
    end
  end

  // Double-banked row store, output word loaded straight from the read port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_store[{fill_bank, wr_idx}] <= probability;
    end
    if (cmd.issue) begin
      value         <= row_store[{drain_bank, drain_ptr}];
      element_index <= ELEM_W'(drain_ptr);
      kept_row      <= drain_tag;
      last          <= status.issue_last;
    end
  end

endmodule

// ----- rtl/core/entropy_score_row_filter.sv -----
// Entropy-gated row filter. Probabilities (Q0.16) enter one word per cycle
// and are grouped into rows of row_length words; each row's entropy (sum of
// -p ln p from a table on the top probability bits, Q8.16, saturating) and
// maximum are gathered as it fills. A row whose entropy is below
// entropy_threshold and whose maximum is above score_threshold is sent out
// in order, one word per cycle while out_stall is low, each word carrying
// its position, the saturating kept-row ordinal and a last flag; other rows
// are dropped. The store has two banks, so a row fills while the previous
// kept row drains: input runs at one word per cycle and stalls only when
// the bank it would fill next is still draining or waiting to drain. After
// the last input word of a kept row is taken (the table read shares the
// accepting edge), the row passes through registered judgement, queueing,
// drain start and store read before its first word is presented, later
// when an earlier kept row is still draining. Consecutive kept rows leave
// a gap in the output while the drain restarts from idle. Configuration
// must be written only while idle; the block itself does not enforce this.
module entropy_score_row_filter
  import esrf_pkg::*;
#(
  parameter int unsigned MAX_ROW_LEN     = MAX_ROW_LEN_DEFAULT,
  parameter int unsigned TERM_TABLE_BITS = TERM_TABLE_BITS_DEFAULT
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PROB_W-1:0]     probability,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PROB_W-1:0]     value,
  output logic [ELEM_W-1:0]     element_index,
  output logic [KEPT_W-1:0]     kept_row,
  output logic                  last,
  input  logic                  config_write,
  input  logic [CFG_IDX_W-1:0]  config_index,
  input  logic [CFG_DATA_W-1:0] config_data
);

  esrf_cmd_t    cmd;
  esrf_status_t status;

  esrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  esrf_datapath #(
    .MAX_ROW_LEN     (MAX_ROW_LEN),
    .TERM_TABLE_BITS (TERM_TABLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .probability   (probability),
    .config_write  (config_write),
    .config_index  (config_index),
    .config_data   (config_data),
    .value         (value),
    .element_index (element_index),
    .kept_row      (kept_row),
    .last          (last)
  );

endmodule

// ----- tb/tb_entropy_score_row_filter.sv -----
module tb_entropy_score_row_filter;
  import esrf_pkg::*;

  localparam int TABLE_BITS      = TERM_TABLE_BITS_DEFAULT;
  localparam int ROW_MAX         = MAX_ROW_LEN_DEFAULT;
  localparam int IDLE_PCT        = 37;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_WORDS    = 300;

  // index past the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [PROB_W-1:0] value;
    logic [ELEM_W-1:0] index;
    logic [KEPT_W-1:0] kept;
    logic              last;
  } row_word_t;

  typedef enum int {SHAPE_PEAKED, SHAPE_NOISE, SHAPE_ZERO, SHAPE_FLAT} row_shape_t;

  // Row filter predictor and queue of words still owed by the block
  class row_filter_scoreboard;
    logic [15:0]       term_lut [2**TABLE_BITS];
    logic [SUM_W-1:0]  ent_limit;
    logic [PROB_W-1:0] score_limit;
    logic [RL_W-1:0]   len_reg;
    logic [PROB_W-1:0] bank [2*ROW_MAX];
    logic [SUM_W-1:0]  ent_acc;
    logic [PROB_W-1:0] peak;
    int unsigned       fill_pos;
    bit                bank_sel;
    logic [KEPT_W-1:0] kept_count;
    row_word_t         due [$];
    int                errors;

    function new();
      int k;
      ent_limit     = ENTROPY_THRESHOLD_RESET;
      score_limit   = SCORE_THRESHOLD_RESET;
      len_reg       = ROW_LENGTH_RESET;
      ent_acc       = '0;
      peak          = '0;
      fill_pos      = 0;
      bank_sel      = 1'b0;
      kept_count    = '0;
      errors        = 0;
      for (k = 0; k < 2**TABLE_BITS; k++) term_lut[k] = term_of_bin(k);
    endfunction

    // log2 in Q.16: whole part exact, fraction by squaring a Q2.30 mantissa
    function longint unsigned log2_fixed(longint unsigned m);
      longint unsigned x;
      longint unsigned frac;
      int unsigned     whole;
      int              i;
      whole = 0;
      frac  = 0;
      while (whole < 31 && (m >> (whole + 1)) != 0) whole++;
      x = m << (30 - whole);
      for (i = 15; i >= 0; i--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x    = x >> 1;
          frac = frac | (64'd1 << i);
        end
      end
      return (64'(whole) << 16) | frac;
    endfunction

    // -p ln p at the bin midpoint, rounded half up, saturated
    function logic [15:0] term_of_bin(int unsigned k);
      longint unsigned m;
      longint unsigned g;
      longint unsigned prod;
      longint unsigned t;
      m    = 64'(2 * k + 1);
      g    = (64'(TABLE_BITS + 1) << 16) - log2_fixed(m);
      prod = m * g * LN2_Q16;
      t    = (prod + (64'd1 << (TABLE_BITS + 16))) >> (TABLE_BITS + 17);
      return (t > 64'd65535) ? 16'hFFFF : t[15:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ENTROPY_THRESHOLD: ent_limit   = data[SUM_W-1:0];
        REG_SCORE_THRESHOLD:   score_limit = data[PROB_W-1:0];
        REG_ROW_LENGTH:        len_reg     = data[RL_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted probability; a closing kept row queues all its words
    function void note_word(logic [PROB_W-1:0] p);
      int unsigned      base;
      int unsigned      count;
      int unsigned      eff;
      int unsigned      i;
      logic [SUM_W:0]   sum;
      logic [KEPT_W-1:0] tag;
      row_word_t        w;
      base = bank_sel ? ROW_MAX : 0;
      if (fill_pos >= ROW_MAX) fill_pos = ROW_MAX - 1;
      bank[base + fill_pos] = p;
      // zero adds nothing to the entropy
      if (p != 0) begin
        sum     = {1'b0, ent_acc} + term_lut[p[PROB_W-1 -: TABLE_BITS]];
        ent_acc = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
      end
      if (p > peak) peak = p;
      count = fill_pos + 1;
      eff   = (len_reg == 0) ? 1 : (len_reg > ROW_MAX) ? ROW_MAX : len_reg;
      if (count < eff) begin
        fill_pos = count;
      end else begin
        if (ent_acc < ent_limit && peak > score_limit) begin
          tag = kept_count;
          if (kept_count != KEPT_MAX) kept_count++;
          for (i = 0; i < count; i++) begin
            w = '{value: bank[base + i], index: ELEM_W'(i), kept: tag,
                  last: 1'(i + 1 == count)};
            due.insert(due.size(), w);
          end
        end
        ent_acc  = '0;
        peak     = '0;
        fill_pos = 0;
        bank_sel = !bank_sel;
      end
    endfunction

    function void check_word(logic [PROB_W-1:0] v, logic [ELEM_W-1:0] idx,
                             logic [KEPT_W-1:0] kr, logic lst);
      row_word_t want;
      row_word_t got;
      got = '{value: v, index: idx, kept: kr, last: lst};
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: value %h index %0d kept_row %0d last %b",
                   v, idx, kr, lst);
      end else begin
        want = due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected value %h index %0d kept_row %0d last %b,",
                      " got value %h index %0d kept_row %0d last %b"},
                     want.value, want.index, want.kept, want.last, v, idx, kr, lst);
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PROB_W-1:0]     probability = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PROB_W-1:0]     value;
  logic [ELEM_W-1:0]     element_index;
  logic [KEPT_W-1:0]     kept_row;
  logic                  last;
  logic                  config_write = 1'b0;
  logic [CFG_IDX_W-1:0]  config_index = '0;
  logic [CFG_DATA_W-1:0] config_data = '0;

  row_filter_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int words_sent = 0;
  int quiet_cycles = 0;

  entropy_score_row_filter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .probability(probability),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .element_index(element_index),
    .kept_row(kept_row),
    .last(last),
    .config_write(config_write),
    .config_index(config_index),
    .config_data(config_data)
  );

  always #10 clk = ~clk;

  // output side: check each accepted word, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_word(value, element_index, kept_row, last);
      out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_entropy_score_row_filter NOT OK");
      $finish;
    end
  end

  function automatic int row_words(logic [RL_W-1:0] len);
    return (len == 0) ? 1 : (len > ROW_MAX) ? ROW_MAX : int'(len);
  endfunction

  // offer one probability, with random gaps, until it is taken
  task automatic send_word(input logic [PROB_W-1:0] p);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    probability <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(p);
    words_sent++;
  endtask

  // stop sending, let every owed word out, then let the pipeline settle
  task automatic hold_off(input int n);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    config_write <= 1'b1;
    config_index <= idx;
    config_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    config_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_row(input row_shape_t shape, input int n);
    int                hot;
    int                i;
    logic [PROB_W-1:0] p;
    hot = $urandom_range(n - 1);
    for (i = 0; i < n; i++) begin
      case (shape)
        SHAPE_PEAKED: p = (i == hot) ? 16'($urandom_range(65535, 40000)) :
                          ($urandom_range(99) < 30) ? '0 : 16'($urandom_range(800));
        SHAPE_NOISE:  p = 16'($urandom());
        SHAPE_ZERO:   p = ($urandom_range(99) < 85) ? '0 : 16'($urandom_range(3));
        default:      p = 16'($urandom_range(65535) >> $urandom_range(6));
      endcase
      send_word(p);
    end
  endtask

  initial begin
    int               phase;
    int               pick;
    int               n;
    int               rows;
    int               r;
    int               words_base;
    logic [RL_W-1:0]  len;
    logic [PROB_W-1:0] score;
    logic [SUM_W-1:0] ent;
    logic [SUM_W-1:0] edge_sum;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // four-word rows: extreme words kept, then an all-zero row dropped
    write_reg(REG_ROW_LENGTH, 24'(4));
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h0001);
    send_word(16'h8000);
    repeat (4) send_word(16'h0000);

    hold_off(SETTLE_CYCLES);
    write_reg(REG_ROW_LENGTH, 24'(1));
    send_word(16'hFFFF);
    send_word(16'h0000);

    // zero length behaves as one
    hold_off(SETTLE_CYCLES);
    write_reg(REG_ROW_LENGTH, 24'(0));
    send_word(16'h1234);

    // maximum must strictly beat the score threshold
    hold_off(SETTLE_CYCLES);
    write_reg(REG_SCORE_THRESHOLD, 24'hFFFF);
    send_word(16'hFFFF);
    hold_off(SETTLE_CYCLES);
    write_reg(REG_SCORE_THRESHOLD, 24'h7FFF);
    send_word(16'h8000);
    send_word(16'h7FFF);

    // entropy must be strictly below its threshold
    hold_off(SETTLE_CYCLES);
    edge_sum = 24'(sb.term_lut[16'h8000 >> (PROB_W - TABLE_BITS)]);
    write_reg(REG_SCORE_THRESHOLD, 24'h0);
    write_reg(REG_ENTROPY_THRESHOLD, edge_sum);
    send_word(16'h8000);
    hold_off(SETTLE_CYCLES);
    write_reg(REG_ENTROPY_THRESHOLD, edge_sum + 24'd1);
    send_word(16'h8000);
    hold_off(SETTLE_CYCLES);
    write_reg(REG_ENTROPY_THRESHOLD, 24'h0);
    send_word(16'hFFFF);

    // spare index ignored; length cut from six to two with three words in
    hold_off(SETTLE_CYCLES);
    write_reg(REG_SPARE, 24'h000001);
    write_reg(REG_ENTROPY_THRESHOLD, 24'hFFFFFF);
    write_reg(REG_ROW_LENGTH, 24'(6));
    send_word(16'h0100);
    send_word(16'hC000);
    send_word(16'h0020);
    hold_off(SETTLE_CYCLES);
    write_reg(REG_ROW_LENGTH, 24'(2));
    send_word(16'h0003);

    // random phases: fresh settings, then rows of varied shape
    phase      = 0;
    words_base = words_sent;
    while (words_sent - words_base < RANDOM_WORDS) begin
      hold_off(SETTLE_CYCLES);
      tx_idle_on = !(phase >= 6 && phase < 10) && (phase % 7 != 3);
      rx_idle_on = !(phase >= 6 && phase < 10) && (phase % 5 != 2);

      pick = $urandom_range(99);
      if (pick < 55) len = 7'($urandom_range(8, 1));
      else if (pick < 75) len = 7'($urandom_range(24, 9));
      else if (pick < 84) len = 7'd0;
      else if (pick < 92) len = 7'd64;
      else len = 7'($urandom_range(127, 65));
      if (phase == 2) len = 7'd127;
      write_reg(REG_ROW_LENGTH, {17'($urandom()), len});
      n = row_words(len);

      pick = $urandom_range(99);
      if (pick < 15) score = '0;
      else if (pick < 25) score = 16'hFFFF;
      else if (pick < 60) score = 16'($urandom_range(2000));
      else score = 16'($urandom());
      write_reg(REG_SCORE_THRESHOLD, {8'($urandom()), score});

      pick = $urandom_range(99);
      if (pick < 10) ent = '0;
      else if (pick < 25) ent = SUM_MAX;
      else if (pick < 45) ent = 24'($urandom());
      else ent = 24'($urandom_range(n * 20000));
      write_reg(REG_ENTROPY_THRESHOLD, ent);

      if ($urandom_range(9) == 0) write_reg(REG_SPARE, 24'($urandom()));

      rows = (n > 24) ? 1 : $urandom_range(4, 1);
      for (r = 0; r < rows; r++) begin
        send_row(row_shape_t'($urandom_range(3)), n);
        // now and then the sender waits for the output to drain completely
        if ($urandom_range(19) == 0) hold_off(1);
      end
      // broken row: may leave a part-filled row for the next setting
      if ($urandom_range(9) == 0) send_row(SHAPE_NOISE, $urandom_range(n, 1));
      phase++;
    end

    // a few short peaked rows to close, idling back on
    hold_off(SETTLE_CYCLES);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_reg(REG_ROW_LENGTH, 24'(3));
    repeat (4) send_row(SHAPE_PEAKED, 3);

    hold_off(2 * SETTLE_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_entropy_score_row_filter OK");
    end else begin
      $display("tb_entropy_score_row_filter NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/esrf_pkg.sv
rtl/core/esrf_ctrl.sv
rtl/core/esrf_datapath.sv
rtl/core/entropy_score_row_filter.sv
tb/tb_entropy_score_row_filter.sv
